@@ hw/rtl/stp_pkg.sv @@
// Shared types, constants and command codes of the step/direction generator.
package stp_pkg;

  // Position and step count widths.
  localparam int unsigned POS_BITS   = 20;
  localparam int unsigned COUNT_BITS = 24;

  // Fixed field widths.
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned VALUE_W    = 20;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned SPM_W      = 16;
  localparam int unsigned WIDTH_W    = 10;
  localparam int unsigned HP_W       = 18;
  localparam int unsigned STEPS_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream payload widths (padded to whole bytes).
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  // Q.8 position times Q.8 steps/mm gives 16 fractional bits.
  localparam int unsigned PROD_FRAC = 16;
  // The half period is base width times a Q.8 ratio.
  localparam int unsigned HP_SHIFT  = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_TARGET = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_POS    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HOME       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_DIR    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ABSOLUTE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_SETUP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_RELEASE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TGT_HOME  = 3'd5;

  // Configuration reset values.
  localparam logic               RST_ABSOLUTE_MODE  = 1'b1;
  localparam logic [SPM_W-1:0]   RST_STEPS_PER_MM   = 16'd10366;
  localparam logic [WIDTH_W-1:0] RST_BASE_WIDTH     = 10'd300;
  localparam logic [WIDTH_W-1:0] RST_DIR_SETUP      = 10'd100;
  localparam logic               RST_HOME_RELEASE   = 1'b1;
  localparam logic               RST_CLEAR_TGT_HOME = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETUP,
    PH_HIGH,
    PH_LOW
  } phase_e;

  typedef struct packed {
    logic [POS_BITS-1:0]   cur_pos;
    logic [POS_BITS-1:0]   tgt_pos;
    logic                  dir;
    logic [COUNT_BITS-1:0] remaining;
    logic [HP_W-1:0]       half_period;
    logic [HP_W-1:0]       timer;
    phase_e                phase;
  } axis_state_t;

  typedef struct packed {
    logic               absolute_mode;
    logic [SPM_W-1:0]   steps_per_mm_q8;
    logic [WIDTH_W-1:0] base_width_us;
    logic [WIDTH_W-1:0] dir_setup_us;
    logic               home_release_dir;
    logic               clear_target_on_home;
  } axis_cfg_t;

endpackage

@@ hw/rtl/stp_move_calc.sv @@
// Move command: direction, step count and half period of the new move.
module stp_move_calc (
  input  stp_pkg::axis_state_t             state_i,
  input  stp_pkg::axis_cfg_t               cfg_i,
  input  logic                             is_negative_i,
  input  logic                             do_move_i,
  input  logic [stp_pkg::RATIO_W-1:0]      ratio_q8_i,
  output stp_pkg::axis_state_t             state_o
);

  localparam int unsigned MAG_W   = stp_pkg::POS_BITS + 1;
  localparam int unsigned MUL_W   = MAG_W + stp_pkg::SPM_W;
  localparam int unsigned RND_W   = MUL_W + 1;
  localparam int unsigned FULL_W  = RND_W - stp_pkg::PROD_FRAC;
  localparam int unsigned SAT_W   = (FULL_W > stp_pkg::COUNT_BITS) ? FULL_W
                                                                   : stp_pkg::COUNT_BITS;
  localparam int unsigned HPP_W   = stp_pkg::WIDTH_W + stp_pkg::RATIO_W;

  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (stp_pkg::PROD_FRAC - 1);
  localparam logic [stp_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  logic signed [MAG_W-1:0]            cur_ext;
  logic signed [MAG_W-1:0]            tgt_ext;
  logic signed [MAG_W-1:0]            disp;
  logic [MAG_W-1:0]                   mag;
  logic [MUL_W-1:0]                   prod;
  logic [RND_W-1:0]                   prod_rnd;
  logic [FULL_W-1:0]                  steps_full;
  logic [stp_pkg::COUNT_BITS-1:0]     steps_sat;
  logic [HPP_W-1:0]                   hp_prod;
  logic [stp_pkg::HP_W-1:0]           hp_raw;
  logic [stp_pkg::HP_W-1:0]           hp;

  // Displacement is taken between sign-extended positions, so it never wraps.
  assign cur_ext  = $signed({state_i.cur_pos[stp_pkg::POS_BITS-1], state_i.cur_pos});
  assign tgt_ext  = $signed({state_i.tgt_pos[stp_pkg::POS_BITS-1], state_i.tgt_pos});
  assign disp     = tgt_ext - cur_ext;
  assign mag      = disp[MAG_W-1] ? MAG_W'(-disp) : MAG_W'(disp);

  // Round half up at 16 fractional bits, then saturate to the counter width.
  assign prod       = MUL_W'(mag) * MUL_W'(cfg_i.steps_per_mm_q8);
  assign prod_rnd   = RND_W'(prod) + ROUND_HALF;
  assign steps_full = prod_rnd[RND_W-1:stp_pkg::PROD_FRAC];
  assign steps_sat  = (SAT_W'(steps_full) > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                               : stp_pkg::COUNT_BITS'(steps_full);

  assign hp_prod = HPP_W'(cfg_i.base_width_us) * HPP_W'(ratio_q8_i);
  assign hp_raw  = hp_prod[stp_pkg::HP_SHIFT +: stp_pkg::HP_W];
  assign hp      = (hp_raw == '0) ? stp_pkg::HP_W'(1) : hp_raw;

  always_comb begin
    state_o = state_i;
    if (cfg_i.absolute_mode) begin
      state_o.dir = (tgt_ext > cur_ext);
    end else begin
      state_o.dir = ~is_negative_i;
    end
    state_o.cur_pos = state_i.tgt_pos;
    if (do_move_i) begin
      state_o.remaining   = steps_sat;
      state_o.half_period = hp;
      state_o.timer       = stp_pkg::HP_W'(cfg_i.dir_setup_us);
      state_o.phase       = stp_pkg::PH_SETUP;
    end
  end

endmodule

@@ hw/rtl/stp_tick_fsm.sv @@
// Tick handling: set-up wait, step high and low phases, home switch blocking.
module stp_tick_fsm (
  input  stp_pkg::axis_state_t state_i,
  input  logic                 home_switch_i,
  input  logic                 home_release_dir_i,
  output stp_pkg::axis_state_t state_o
);

  logic                           start_step;
  logic [stp_pkg::COUNT_BITS-1:0] cnt_base;
  logic                           timer_run;

  assign timer_run = (state_i.timer > stp_pkg::HP_W'(1));

  always_comb begin
    state_o    = state_i;
    start_step = 1'b0;
    cnt_base   = state_i.remaining;
    case (state_i.phase)
      stp_pkg::PH_SETUP: begin
        if (timer_run) begin
          state_o.timer = state_i.timer - stp_pkg::HP_W'(1);
        end else begin
          start_step = 1'b1;
        end
      end
      stp_pkg::PH_HIGH: begin
        if (timer_run) begin
          state_o.timer = state_i.timer - stp_pkg::HP_W'(1);
        end else begin
          state_o.phase = stp_pkg::PH_LOW;
          state_o.timer = state_i.half_period;
        end
      end
      stp_pkg::PH_LOW: begin
        if (timer_run) begin
          state_o.timer = state_i.timer - stp_pkg::HP_W'(1);
        end else begin
          start_step = 1'b1;
          if (state_i.remaining != '0) begin
            cnt_base = state_i.remaining - stp_pkg::COUNT_BITS'(1);
          end
        end
      end
      default: begin
        state_o.phase = stp_pkg::PH_IDLE;
      end
    endcase

    // A closed home switch drops the whole rest of the move unless the
    // axis is moving in the release direction.
    if (start_step) begin
      state_o.remaining = cnt_base;
      if (cnt_base == '0) begin
        state_o.phase = stp_pkg::PH_IDLE;
      end else if (home_switch_i && (state_i.dir != home_release_dir_i)) begin
        state_o.remaining = '0;
        state_o.phase     = stp_pkg::PH_IDLE;
      end else begin
        state_o.phase = stp_pkg::PH_HIGH;
        state_o.timer = state_i.half_period;
      end
    end
  end

endmodule

@@ hw/rtl/stepper_axis_step_dir_generator.sv @@
// Top level of one plotter axis: step/direction pulse generator with stream ports.
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   s_axis_tvalid/tready   tdata: command operands, tuser: command code
//  m_axis    out  m_axis_tvalid/tready   tdata: pin levels and counters, tuser: status
//  cfg       in   cfg_valid_i/ready_o    cfg_index_i register, cfg_data_i value
//
// One beat is accepted per clock cycle while results are taken; each beat gives
// exactly one result beat (input register, then result register). The step of the
// axis state between those registers, with its two small multipliers for a move,
// sets that rate. Reset loads the configuration defaults, puts the axis idle at
// position zero and empties both registers. While the result is not taken the input
// register still holds one beat; s_axis_tready falls only when both are full.
// Configuration writes are always ready and take effect on the next cycle.
module stepper_axis_step_dir_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: value[19:0], is_negative, do_move, ratio_q8[15:0], home_switch
  input  logic [stp_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [stp_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: step_out, dir_out, busy_res, position[19:0], steps_left[23:0]
  output logic [stp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // tuser: status
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [stp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned BUSY_BIT = 2;

  // Configuration registers.
  stp_pkg::axis_cfg_t cfg_q;

  // Input register.
  logic                              in_valid_q;
  logic                              in_valid_d;
  logic [stp_pkg::CMD_W-1:0]         in_cmd_q;
  logic [stp_pkg::VALUE_W-1:0]       in_value_q;
  logic                              in_is_negative_q;
  logic                              in_do_move_q;
  logic [stp_pkg::RATIO_W-1:0]       in_ratio_q;
  logic                              in_home_q;

  // Axis state.
  stp_pkg::axis_state_t state_q;
  stp_pkg::axis_state_t state_d;
  stp_pkg::axis_state_t tick_state;
  stp_pkg::axis_state_t move_state;

  // Result register.
  logic                              out_valid_q;
  logic                              out_valid_d;
  logic [stp_pkg::M_TDATA_W-1:0]     out_tdata_q;
  logic [stp_pkg::M_TDATA_W-1:0]     out_tdata_d;
  logic                              out_tuser_q;
  logic                              status_d;

  logic                              s_accept;
  logic                              advance;
  logic                              busy;
  logic [stp_pkg::POS_BITS-1:0]      value_pos;

  // The result register frees up in the same cycle it is taken, so the input
  // register can move forward without a bubble.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_accept || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

  // Positions arrive as signed Q.8 millimetres.
  assign value_pos = stp_pkg::POS_BITS'($signed(in_value_q));
  assign busy      = (state_q.phase != stp_pkg::PH_IDLE);

  stp_tick_fsm u_tick (
    .state_i            (state_q),
    .home_switch_i      (in_home_q),
    .home_release_dir_i (cfg_q.home_release_dir),
    .state_o            (tick_state)
  );

  stp_move_calc u_move (
    .state_i       (state_q),
    .cfg_i         (cfg_q),
    .is_negative_i (in_is_negative_q),
    .do_move_i     (in_do_move_q),
    .ratio_q8_i    (in_ratio_q),
    .state_o       (move_state)
  );

  // Command decode. Commands up to CMD_SET_DIR other than a tick are refused while a
  // move runs; a refused command leaves the state alone and time does not advance.
  always_comb begin
    state_d  = state_q;
    status_d = 1'b0;
    if (in_cmd_q == stp_pkg::CMD_TICK) begin
      state_d = tick_state;
    end else if ((in_cmd_q <= stp_pkg::CMD_SET_DIR) && busy) begin
      status_d = 1'b1;
    end else begin
      case (in_cmd_q)
        stp_pkg::CMD_SET_TARGET: begin
          if (cfg_q.absolute_mode) begin
            state_d.tgt_pos = value_pos;
          end else begin
            state_d.tgt_pos = state_q.tgt_pos + value_pos;
          end
        end
        stp_pkg::CMD_SET_POS: begin
          state_d.cur_pos = value_pos;
        end
        stp_pkg::CMD_MOVE: begin
          state_d = move_state;
        end
        stp_pkg::CMD_HOME: begin
          state_d.cur_pos = '0;
          if (cfg_q.clear_target_on_home) begin
            state_d.tgt_pos = '0;
          end
        end
        stp_pkg::CMD_SET_DIR: begin
          state_d.dir = in_value_q[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The result shows the state after this beat has been applied.
  assign out_tdata_d = {
    1'b0,
    stp_pkg::STEPS_W'(state_d.remaining),
    stp_pkg::VALUE_W'(state_d.cur_pos),
    (state_d.phase != stp_pkg::PH_IDLE),
    state_d.dir,
    (state_d.phase == stp_pkg::PH_HIGH)
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.absolute_mode        <= stp_pkg::RST_ABSOLUTE_MODE;
      cfg_q.steps_per_mm_q8      <= stp_pkg::RST_STEPS_PER_MM;
      cfg_q.base_width_us        <= stp_pkg::RST_BASE_WIDTH;
      cfg_q.dir_setup_us         <= stp_pkg::RST_DIR_SETUP;
      cfg_q.home_release_dir     <= stp_pkg::RST_HOME_RELEASE;
      cfg_q.clear_target_on_home <= stp_pkg::RST_CLEAR_TGT_HOME;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        stp_pkg::REG_ABSOLUTE_MODE:  cfg_q.absolute_mode        <= cfg_data_i[0];
        stp_pkg::REG_STEPS_PER_MM:   cfg_q.steps_per_mm_q8      <= cfg_data_i;
        stp_pkg::REG_BASE_WIDTH:     cfg_q.base_width_us        <=
                                       cfg_data_i[stp_pkg::WIDTH_W-1:0];
        stp_pkg::REG_DIR_SETUP:      cfg_q.dir_setup_us         <=
                                       cfg_data_i[stp_pkg::WIDTH_W-1:0];
        stp_pkg::REG_HOME_RELEASE:   cfg_q.home_release_dir     <= cfg_data_i[0];
        stp_pkg::REG_CLEAR_TGT_HOME: cfg_q.clear_target_on_home <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{default: '0, phase: stp_pkg::PH_IDLE};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_value_q       <= s_axis_tdata[19:0];
      in_is_negative_q <= s_axis_tdata[20];
      in_do_move_q     <= s_axis_tdata[21];
      in_ratio_q       <= s_axis_tdata[37:22];
      in_home_q        <= s_axis_tdata[38];
      in_cmd_q         <= s_axis_tuser;
    end
    if (advance) begin
      out_tdata_q <= out_tdata_d;
      out_tuser_q <= status_d;
    end
  end

  // An idle axis never has steps left over.
  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == stp_pkg::PH_IDLE) |-> (state_q.remaining == '0))
    else $error("idle axis with steps remaining");

  // Pulse phases always run with a nonzero timer.
  a_pulse_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q.phase == stp_pkg::PH_HIGH) || (state_q.phase == stp_pkg::PH_LOW))
      |-> (state_q.timer != '0))
    else $error("pulse phase with zero timer");

  // A refused command leaves the axis state untouched.
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_cmd_q != stp_pkg::CMD_TICK) && (in_cmd_q <= stp_pkg::CMD_SET_DIR)
      && (state_q.phase != stp_pkg::PH_IDLE)) |=> $stable(state_q))
    else $error("refused command changed the axis state");

  // A refusal is only reported while the axis is busy.
  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tuser_q) |-> out_tdata_q[BUSY_BIT])
    else $error("refusal reported on an idle axis");

endmodule

@@ tb/stepper_axis_step_dir_generator_tb.sv @@
// Self-checking testbench for the stepper axis step/direction generator.
module stepper_axis_step_dir_generator_tb;
  import stp_pkg::*;

  // A stall of the whole block longer than this many cycles means it hung.
  // The longest legitimate quiet stretch is the forced receiver
  // hold-off plus a sender gap.
  localparam int     STALL_LIMIT = 2000;
  localparam int     HOLD_OFF    = 300;
  localparam int     RANDOM_BEATS = 500;
  localparam longint STEPS_MAX   = (64'd1 << COUNT_BITS) - 1;

  // One command beat as the block sees it, unpacked into its fields.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               is_neg;
    logic               do_move;
    logic [RATIO_W-1:0] ratio;
    logic               home;
  } axis_cmd_t;

  // One result beat: pin levels, counters, the busy flag and the refusal status.
  typedef struct packed {
    logic                  step;
    logic                  dir;
    logic                  busy;
    logic [POS_BITS-1:0]   pos;
    logic [COUNT_BITS-1:0] steps;
    logic                  status;
  } axis_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predicted axis state and the register copy that goes with it.
  axis_cfg_t             m_cfg;
  logic [POS_BITS-1:0]   m_cur;
  logic [POS_BITS-1:0]   m_tgt;
  logic                  m_dir;
  logic [COUNT_BITS-1:0] m_left;
  logic [HP_W-1:0]       m_hp;
  logic [HP_W-1:0]       m_timer;
  phase_e                m_phase;

  // Expected result beats, oldest first.
  axis_res_t expected_pins_q[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  beats_sent = 0;
  int  effective_items = 0;
  int  moves_started = 0;
  int  rejected_cmds = 0;
  int  home_stops = 0;
  int  cfg_writes = 0;
  int  stall_cycles = 0;
  int  rx_hold_req = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  stepper_axis_step_dir_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Gap lengths for both sides: mostly back to back, some short pauses and
  // now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic axis_cmd_t mk_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                       logic is_neg, logic do_move,
                                       logic [RATIO_W-1:0] ratio, logic home);
    axis_cmd_t c;
    c.cmd     = cmd;
    c.value   = value;
    c.is_neg  = is_neg;
    c.do_move = do_move;
    c.ratio   = ratio;
    c.home    = home;
    return c;
  endfunction

  // A beat with every field random and the command code in [lo, hi].
  function automatic axis_cmd_t random_beat(int lo, int hi);
    return mk_cmd(CMD_W'($urandom_range(lo, hi)), VALUE_W'($urandom),
                  1'($urandom), 1'($urandom), RATIO_W'($urandom), 1'($urandom));
  endfunction

  // A step is due: either start the high half of the next pulse, go idle
  // because the count ran out, or drop the rest of the move because the home
  // switch is closed and we are not heading away from it.
  function automatic void start_pulse(logic home);
    if (m_left == '0) begin
      m_phase = PH_IDLE;
    end else if (home && m_dir != m_cfg.home_release_dir) begin
      m_left  = '0;
      m_phase = PH_IDLE;
      home_stops++;
    end else begin
      m_phase = PH_HIGH;
      m_timer = m_hp;
    end
  endfunction

  // One microsecond tick of the pulse timer.
  function automatic void advance_tick(logic home);
    case (m_phase)
      PH_SETUP: begin
        if (m_timer > 1) m_timer--;
        else start_pulse(home);
      end
      PH_HIGH: begin
        if (m_timer > 1) begin
          m_timer--;
        end else begin
          m_phase = PH_LOW;
          m_timer = m_hp;
        end
      end
      PH_LOW: begin
        if (m_timer > 1) begin
          m_timer--;
        end else begin
          if (m_left != '0) m_left--;
          start_pulse(home);
        end
      end
      default: ;
    endcase
  endfunction

  // A move: direction from the position compare (absolute mode) or the sign
  // flag (relative mode), the target becomes the position, and with do_move
  // the step count is the rounded product of the distance and steps/mm.
  function automatic void start_move(axis_cmd_t c);
    longint cur_s;
    longint tgt_s;
    longint delta;
    longint steps;
    longint hp;
    cur_s = $signed(m_cur);
    tgt_s = $signed(m_tgt);
    delta = tgt_s - cur_s;
    if (m_cfg.absolute_mode) m_dir = (tgt_s > cur_s);
    else m_dir = !c.is_neg;
    m_cur = m_tgt;
    if (c.do_move) begin
      if (delta < 0) delta = -delta;
      steps = (delta * longint'(m_cfg.steps_per_mm_q8) + (64'd1 << (PROD_FRAC - 1)))
              >> PROD_FRAC;
      if (steps > STEPS_MAX) steps = STEPS_MAX;
      m_left = steps[COUNT_BITS-1:0];
      hp = (longint'(m_cfg.base_width_us) * longint'(c.ratio)) >> HP_SHIFT;
      if (hp == 0) hp = 1;
      m_hp    = hp[HP_W-1:0];
      m_phase = PH_SETUP;
      m_timer = HP_W'(m_cfg.dir_setup_us);
      moves_started++;
    end
  endfunction

  // Apply one command beat to the predicted state and return the result
  // beat the block must answer with.
  function automatic axis_res_t predict_axis(axis_cmd_t c);
    axis_res_t r;
    logic      rejected;
    rejected = 1'b0;
    if (c.cmd == CMD_TICK) begin
      advance_tick(c.home);
    end else if (c.cmd <= CMD_SET_DIR && m_phase != PH_IDLE) begin
      rejected = 1'b1;
      rejected_cmds++;
    end else begin
      case (c.cmd)
        CMD_SET_TARGET: m_tgt = m_cfg.absolute_mode ? c.value : m_tgt + c.value;
        CMD_SET_POS:    m_cur = c.value;
        CMD_MOVE:       start_move(c);
        CMD_HOME: begin
          m_cur = '0;
          if (m_cfg.clear_target_on_home) m_tgt = '0;
        end
        CMD_SET_DIR:    m_dir = c.value[0];
        default: ;
      endcase
    end
    r.step   = (m_phase == PH_HIGH);
    r.dir    = m_dir;
    r.busy   = (m_phase != PH_IDLE);
    r.pos    = m_cur;
    r.steps  = m_left;
    r.status = rejected;
    return r;
  endfunction

  function automatic void report_mismatch(string what, axis_res_t want, axis_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at result %0d: expected step=%0b dir=%0b busy=%0b pos=%0d left=%0d st=%0b",
               what, results_seen, want.step, want.dir, want.busy, $signed(want.pos),
               want.steps, want.status);
      $display("    got step=%0b dir=%0b busy=%0b pos=%0d left=%0d st=%0b",
               got.step, got.dir, got.busy, $signed(got.pos), got.steps, got.status);
    end
  endfunction

  // Offer one command beat after a random gap and wait for the handshake.
  // The prediction is taken at the edge that accepts the beat, so the
  // predicted state always covers exactly the beats the block has taken.
  task automatic send_beat(axis_cmd_t c);
    int gap;
    bit ignored;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, c.home, c.ratio, c.do_move, c.is_neg, c.value};
    s_axis_tuser  <= c.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ignored = (c.cmd == CMD_TICK && m_phase == PH_IDLE) || (c.cmd > CMD_SET_DIR);
    if (!ignored) effective_items++;
    beats_sent++;
    expected_pins_q.push_back(predict_axis(c));
  endtask

  // Stop offering beats and wait until every result beat is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_pins_q.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the pipeline empty and the axis idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ABSOLUTE_MODE:  m_cfg.absolute_mode        = data[0];
      REG_STEPS_PER_MM:   m_cfg.steps_per_mm_q8      = data[SPM_W-1:0];
      REG_BASE_WIDTH:     m_cfg.base_width_us        = data[WIDTH_W-1:0];
      REG_DIR_SETUP:      m_cfg.dir_setup_us         = data[WIDTH_W-1:0];
      REG_HOME_RELEASE:   m_cfg.home_release_dir     = data[0];
      REG_CLEAR_TGT_HOME: m_cfg.clear_target_on_home = data[0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Tick until the predicted move is over. home_mode 0 and 1 hold the home
  // switch at that level, 2 closes it now and then. With noisy set, some
  // ticks are replaced by random commands, which the block must reject or ignore.
  task automatic run_until_idle(int home_mode, bit noisy);
    axis_cmd_t c;
    logic      home;
    while (m_phase != PH_IDLE) begin
      home = (home_mode == 2) ? ($urandom_range(0, 15) == 0) : home_mode[0];
      if (noisy && $urandom_range(0, 7) == 0) c = random_beat(1, 7);
      else c = mk_cmd(CMD_TICK, '0, 1'b0, 1'b0, '0, home);
      send_beat(c);
    end
  endtask

  task automatic tick(logic home);
    send_beat(mk_cmd(CMD_TICK, '0, 1'b0, 1'b0, '0, home));
  endtask

  // Reset settings: a plain absolute move, a command and an unknown code while
  // the axis is busy, and an unknown code while idle.
  task automatic test_defaults_move();
    send_beat(mk_cmd(CMD_SET_TARGET, 20'd128, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b1, 16'd1, 1'b0));
    tick(1'b0);
    send_beat(mk_cmd(CMD_SET_POS, 20'h7FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1));
    send_beat(mk_cmd(3'd6, 20'hFFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1));
    run_until_idle(0, 1'b0);
    send_beat(mk_cmd(3'd7, 20'h55555, 1'b0, 1'b1, 16'hAAAA, 1'b0));
  endtask

  // Every register at an extreme: relative targets, the largest steps/mm,
  // zero width and zero set-up; then the home switch stopping a move before
  // its first step and in the middle, and homing that clears the target.
  task automatic test_register_extremes();
    write_reg(REG_ABSOLUTE_MODE, 16'd0);
    write_reg(REG_STEPS_PER_MM, 16'hFFFF);
    write_reg(REG_BASE_WIDTH, 16'd0);
    write_reg(REG_DIR_SETUP, 16'd0);
    write_reg(REG_HOME_RELEASE, 16'd0);
    write_reg(REG_CLEAR_TGT_HOME, 16'd1);
    send_beat(mk_cmd(CMD_SET_TARGET, 20'd3, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b1, 1'b1, 16'hFFFF, 1'b0));
    // Direction 0 matches the release direction, so the closed switch is ignored.
    run_until_idle(1, 1'b0);
    write_reg(REG_HOME_RELEASE, 16'd1);
    send_beat(mk_cmd(CMD_SET_TARGET, 20'd2, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b1, 1'b1, 16'd0, 1'b0));
    run_until_idle(1, 1'b0);
    send_beat(mk_cmd(CMD_SET_TARGET, 20'd3, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b1, 1'b1, 16'd0, 1'b0));
    tick(1'b0);
    tick(1'b0);
    run_until_idle(1, 1'b0);
    send_beat(mk_cmd(CMD_HOME, '0, 1'b0, 1'b0, '0, 1'b0));
  endtask

  // The widest set-up time and the widest base width, then a ratio with its
  // top bit set that gives a long pulse.
  task automatic test_wide_pulse();
    write_reg(REG_ABSOLUTE_MODE, 16'd1);
    write_reg(REG_STEPS_PER_MM, 16'd256);
    write_reg(REG_BASE_WIDTH, 16'd1023);
    write_reg(REG_DIR_SETUP, 16'd1023);
    send_beat(mk_cmd(CMD_SET_POS, '0, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_SET_TARGET, 20'd256, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b1, 16'd1, 1'b0));
    run_until_idle(0, 1'b0);
    write_reg(REG_BASE_WIDTH, 16'd1);
    write_reg(REG_DIR_SETUP, 16'd1);
    send_beat(mk_cmd(CMD_SET_TARGET, '0, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b1, 16'h80FF, 1'b0));
    run_until_idle(0, 1'b0);
  endtask

  // Positions at both ends of the range: a move without stepping, a full
  // span move whose distance does not fit the position width, homing that
  // keeps the target, a zero-length move and relative target wrap-around.
  task automatic test_full_span();
    write_reg(REG_STEPS_PER_MM, 16'd1);
    write_reg(REG_BASE_WIDTH, 16'd0);
    write_reg(REG_DIR_SETUP, 16'd0);
    write_reg(REG_CLEAR_TGT_HOME, 16'd0);
    send_beat(mk_cmd(CMD_SET_POS, 20'h80000, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_SET_TARGET, 20'h7FFFF, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_SET_DIR, 20'hFFFFE, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_SET_POS, 20'h80000, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b1, 16'd7, 1'b0));
    run_until_idle(0, 1'b0);
    send_beat(mk_cmd(CMD_HOME, '0, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b1, '0, 1'b0));
    run_until_idle(0, 1'b0);
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b1, '0, 1'b0));
    run_until_idle(0, 1'b0);
    write_reg(REG_ABSOLUTE_MODE, 16'd0);
    send_beat(mk_cmd(CMD_SET_TARGET, 20'd1, 1'b0, 1'b0, '0, 1'b0));
    send_beat(mk_cmd(CMD_MOVE, '0, 1'b0, 1'b0, '0, 1'b0));
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering beats back to back, so both registers fill and the input stalls.
  task automatic test_backpressure();
    tx_steady   = 1'b1;
    rx_hold_req = HOLD_OFF;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(mk_cmd(CMD_SET_DIR, VALUE_W'($urandom), 1'b0, 1'b0, '0, 1'b0));
      else
        tick(1'($urandom));
    end
    tx_steady = 1'b0;
  endtask

  // Random register settings and well-formed moves with random content,
  // with garbage commands while idle and noise while a move runs.
  task automatic test_random_moves();
    int        goal;
    int        mag_lim;
    int        offset;
    longint    cur_s;
    longint    aim;
    int        ratio_lim;
    axis_cmd_t c;
    logic [POS_BITS-1:0] aim_pos;
    goal = effective_items + RANDOM_BEATS;
    while (effective_items < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_ABSOLUTE_MODE, 16'($urandom_range(0, 1)));
        write_reg(REG_STEPS_PER_MM, ($urandom_range(0, 3) == 0) ?
                  16'($urandom_range(0, 65535)) : 16'($urandom_range(1, 2000)));
        write_reg(REG_BASE_WIDTH, ($urandom_range(0, 19) == 0) ?
                  16'd1023 : 16'($urandom_range(0, 6)));
        write_reg(REG_DIR_SETUP, ($urandom_range(0, 19) == 0) ?
                  16'($urandom_range(6, 40)) : 16'($urandom_range(0, 5)));
        write_reg(REG_HOME_RELEASE, 16'($urandom_range(0, 1)));
        write_reg(REG_CLEAR_TGT_HOME, 16'($urandom_range(0, 1)));
      end
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      // Garbage while idle: anything but a move, which would take the
      // garbage target and could run for a very long time.
      repeat ($urandom_range(0, 3)) begin
        c = random_beat(0, 7);
        if (c.cmd == CMD_MOVE) c.cmd = CMD_SET_DIR;
        send_beat(c);
      end
      if ($urandom_range(0, 2) == 0)
        send_beat(mk_cmd(CMD_SET_POS, VALUE_W'($urandom), 1'b0, 1'b0, '0, 1'b0));
      // Pick a target close enough that the move takes at most about ten steps.
      if (m_cfg.steps_per_mm_q8 == '0) mag_lim = 4000;
      else mag_lim = (10 << PROD_FRAC) / int'(m_cfg.steps_per_mm_q8);
      if (mag_lim > 500000) mag_lim = 500000;
      offset = int'($urandom_range(0, 2 * mag_lim)) - mag_lim;
      cur_s  = $signed(m_cur);
      aim    = cur_s + offset;
      if (aim > 524287 || aim < -524288) aim = cur_s - offset;
      aim_pos = aim[POS_BITS-1:0];
      if (!m_cfg.absolute_mode) aim_pos = aim_pos - m_tgt;
      send_beat(mk_cmd(CMD_SET_TARGET, aim_pos, 1'($urandom), 1'($urandom),
                       RATIO_W'($urandom), 1'($urandom)));
      // Keep the half period within a few ticks.
      if (m_cfg.base_width_us == '0) ratio_lim = 65535;
      else ratio_lim = 1024 / int'(m_cfg.base_width_us);
      send_beat(mk_cmd(CMD_MOVE, '0, 1'($urandom), ($urandom_range(0, 9) != 0),
                       RATIO_W'($urandom_range(0, ratio_lim)), 1'($urandom)));
      run_until_idle(2, 1'b1);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver side: random gaps in tready, plus a forced hold-off that a test
  // can request and that this process counts down itself.
  initial begin : rx_side
    int gap_left;
    gap_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        gap_left    = rx_hold_req;
        rx_hold_req = 0;
      end else if (gap_left == 0 && !rx_steady) begin
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        m_axis_tready <= 1'b0;
        gap_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    axis_res_t got;
    axis_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.step   = m_axis_tdata[0];
      got.dir    = m_axis_tdata[1];
      got.busy   = m_axis_tdata[2];
      got.pos    = m_axis_tdata[3 +: POS_BITS];
      got.steps  = m_axis_tdata[3 + POS_BITS +: COUNT_BITS];
      got.status = m_axis_tuser;
      if (expected_pins_q.size() == 0) begin
        report_mismatch("unexpected result beat", '0, got);
      end else begin
        want = expected_pins_q.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("stepper_axis_step_dir_generator: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    m_cfg.absolute_mode        = RST_ABSOLUTE_MODE;
    m_cfg.steps_per_mm_q8      = RST_STEPS_PER_MM;
    m_cfg.base_width_us        = RST_BASE_WIDTH;
    m_cfg.dir_setup_us         = RST_DIR_SETUP;
    m_cfg.home_release_dir     = RST_HOME_RELEASE;
    m_cfg.clear_target_on_home = RST_CLEAR_TGT_HOME;
    m_cur   = '0;
    m_tgt   = '0;
    m_dir   = 1'b0;
    m_left  = '0;
    m_hp    = '0;
    m_timer = '0;
    m_phase = PH_IDLE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_defaults_move();
    test_register_extremes();
    test_wide_pulse();
    test_full_span();
    test_backpressure();
    test_random_moves();

    // Let the last results come back, then keep the clock running to catch any
    // stray beat from the two-stage pipeline.
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d command beats (%0d doing work): %0d moves, %0d rejected while busy,",
             beats_sent, effective_items, moves_started, rejected_cmds);
    $display("%0d stopped by the home switch; %0d register writes, %0d results, %0d bad.",
             home_stops, cfg_writes, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("stepper_axis_step_dir_generator: match");
    end else begin
      $display("stepper_axis_step_dir_generator: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/stp_pkg.sv
hw/rtl/stp_move_calc.sv
hw/rtl/stp_tick_fsm.sv
hw/rtl/stepper_axis_step_dir_generator.sv
tb/stepper_axis_step_dir_generator_tb.sv
